### sv/rcpwm_pkg.sv
// shared types and constants for the rc pwm channel decoder
package rcpwm_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PULSE_MIN     = 3'd0;
  localparam logic [2:0] REG_PULSE_MAX     = 3'd1;
  localparam logic [2:0] REG_PITCH_ZERO    = 3'd2;
  localparam logic [2:0] REG_ROLL_ZERO     = 3'd3;
  localparam logic [2:0] REG_THROTTLE_ZERO = 3'd4;
  localparam logic [2:0] REG_PROCESS_VAR   = 3'd5;
  localparam logic [2:0] REG_MEASURE_VAR   = 3'd6;
  localparam logic [2:0] REG_PROTECT_SPEED = 3'd7;

  // channel codes
  localparam logic [2:0] CH_PITCH    = 3'd0;
  localparam logic [2:0] CH_ROLL     = 3'd1;
  localparam logic [2:0] CH_THROTTLE = 3'd2;
  localparam logic [2:0] CH_DIAL     = 3'd5;

  localparam logic [11:0] PITCH_FALLBACK    = 12'd1500;
  localparam logic [11:0] ROLL_FALLBACK     = 12'd1500;
  localparam logic [11:0] THROTTLE_FALLBACK = 12'd1100;
  localparam logic signed [12:0] ROLL_EXTREME = 13'sd160;

  localparam logic [17:0] TILT_SQ_LIMIT = 18'd144000;
  localparam logic [31:0] PI_Q30        = 32'd3373259426;
  localparam logic [33:0] TILT_DEN      = 34'd10616832000;
  localparam logic [33:0] TILT_HALF     = 34'd5308416000;

  // TILT_DEN is 10125 << 20: drop the low 20 bits, then divide by 10125
  // through ceil(2^43 / 10125), exact for a 29-bit numerator
  localparam int          TILT_SHIFT     = 20;
  localparam int          TILT_RCP_SHIFT = 43;
  localparam logic [29:0] TILT_RCP       = 30'd868749929;

  // shared divider geometry: quotient always fits in DIV_QW bits
  localparam int DIV_NW = 51;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 24;

  typedef struct packed {
    logic [2:0]  ch;
    logic [11:0] raw;
    logic        locked;
    logic        manual;
  } job_t;

  typedef struct packed {
    logic [11:0] pulse_min;
    logic [11:0] pulse_max;
  } window_t;

endpackage

### sv/rcpwm_fifo.sv
// short job queue between the edge front end and the filter back end
module rcpwm_fifo
  import rcpwm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       mem [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign pop_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 2'd1;
      if (pop && !empty) rptr <= rptr + 2'd1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/rcpwm_front.sv
// edge capture: pulse start times, width measurement and window check
module rcpwm_front
  import rcpwm_pkg::*;
#(
  parameter int NUM_CHANNELS = 6,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_ch,
  input  logic                  in_level,
  input  logic [TIME_WIDTH-1:0] in_time,
  input  logic                  in_locked,
  input  logic                  in_manual,
  input  window_t               win,
  output logic                  push,
  output job_t                  push_job,
  input  logic                  full
);

  localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [TIME_WIDTH-1:0] pulse_start [2**CH_IW];
  logic [TIME_WIDTH-1:0] raw;
  logic                  ch_ok;
  logic                  accept;
  logic                  in_win;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign ch_ok    = (32'(in_ch) < NUM_CHANNELS);
  assign raw      = in_time - pulse_start[in_ch[CH_IW-1:0]];
  assign in_win   = (raw >= TIME_WIDTH'(win.pulse_min)) && (raw <= TIME_WIDTH'(win.pulse_max));
  assign push     = accept && ch_ok && !in_level && in_win;

  always_comb begin
    push_job.ch     = in_ch;
    push_job.raw    = raw[11:0];
    push_job.locked = in_locked;
    push_job.manual = in_manual;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2**CH_IW; i++) pulse_start[i] <= '0;
    end else if (accept && ch_ok && in_level) begin
      pulse_start[in_ch[CH_IW-1:0]] <= in_time;
    end
  end

endmodule

### sv/rcpwm_div.sv
// restoring divider, one quotient bit per cycle
module rcpwm_div
  import rcpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_QW-1:0] quotient
);

  localparam int CW = $clog2(DIV_QW + 1);

  logic [DIV_DW:0]   rem;
  logic [DIV_QW-1:0] qd;
  logic [DIV_DW-1:0] dsr;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] trial;

  assign shifted  = {rem[DIV_DW-1:0], qd[DIV_QW-1]};
  assign trial    = {1'b0, shifted} - {2'b0, dsr};
  assign quotient = qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= (DIV_DW+1)'(dividend[DIV_NW-1:DIV_QW]);
      qd  <= dividend[DIV_QW-1:0];
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[DIV_DW+1]) begin
        rem <= trial[DIV_DW:0];
        qd  <= {qd[DIV_QW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        qd  <= {qd[DIV_QW-2:0], 1'b0};
      end
    end
  end

endmodule

### sv/rcpwm_back.sv
// filter, tilt, throttle and lock processing with configuration and result register
module rcpwm_back
  import rcpwm_pkg::*;
#(
  parameter int SPEED_MAX = 1000,
  parameter int SPEED_MIN = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output window_t     win,
  input  logic        empty,
  input  job_t        pop_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_DIVS1 = 4'd3;
  localparam logic [3:0] S_DIVW1 = 4'd4;
  localparam logic [3:0] S_DIVS2 = 4'd5;
  localparam logic [3:0] S_DIVW2 = 4'd6;
  localparam logic [3:0] S_APPLY = 4'd7;
  localparam logic [3:0] S_TMUL  = 4'd8;
  localparam logic [3:0] S_TRCP  = 4'd9;
  localparam logic [3:0] S_TOUT  = 4'd10;

  localparam logic signed [13:0] SMAX = 14'(SPEED_MAX);
  localparam logic signed [13:0] SMIN = 14'(SPEED_MIN);

  logic [11:0] pulse_min, pulse_max, pitch_zero, roll_zero, throttle_zero;
  logic [23:0] process_var, measure_var;
  logic [9:0]  protect_speed;

  logic [19:0] width_estimate [4];
  logic [23:0] estimate_variance [4];
  logic [2:0]  lock_bits;

  logic [3:0]        state;
  job_t              job;
  logic [1:0]        slot;
  logic [24:0]       q2;
  logic [25:0]       den;
  logic [19:0]       est_cur;
  logic [19:0]       est_new;
  logic              meas_lo;
  logic [DIV_NW-1:0] prod;
  logic [DIV_DW-1:0] divisor;
  logic [11:0]       w;
  logic [17:0]       sq;
  logic              neg;
  logic [58:0]       tilt_prod;
  logic [15:0]       tilt_mag;

  logic              div_start;
  logic              div_done;
  logic [DIV_QW-1:0] div_q;

  logic [19:0] meas;
  logic        filt;

  logic              applied;
  logic [11:0]       zero_sel;
  logic              zero_ok;
  logic signed [12:0] d;
  logic [11:0]       mag;
  logic [23:0]       mag_sq;
  logic signed [13:0] v;
  logic [16:0]       tilt_res;
  logic              speed_hit;
  logic [2:0]        lock_next;

  logic       o_applied;
  logic [16:0] o_tilt;
  logic       o_tv;
  logic [9:0] o_speed;
  logic       o_sv;
  logic [2:0] o_ch;
  logic [11:0] o_w;
  logic [2:0] o_lock;

  assign win.pulse_min = pulse_min;
  assign win.pulse_max = pulse_max;
  assign out_data = {o_lock, o_sv, o_speed, o_tv, o_tilt, o_applied, o_w, o_ch};

  assign pop  = (state == S_IDLE) && !empty && (!out_valid || out_ready);
  assign meas = {job.raw, 8'd0};
  assign filt = (job.ch == CH_PITCH) || (job.ch == CH_ROLL) ||
                (job.ch == CH_THROTTLE) || (job.ch == CH_DIAL);
  assign div_start = (state == S_DIVS1) || (state == S_DIVS2);

  // rounded sum shifted down, then times the reciprocal of 10125
  assign tilt_prod = 59'(prod[TILT_SHIFT+28:TILT_SHIFT]) * 59'(TILT_RCP);

  rcpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // window check, centre selection with fallback, signed offset, speed clamp, lock bits and tilt sign
  always_comb begin
    applied = (w >= pulse_min) && (w <= pulse_max);
    unique case (job.ch)
      CH_PITCH:    zero_sel = pitch_zero;
      CH_ROLL:     zero_sel = roll_zero;
      default:     zero_sel = throttle_zero;
    endcase
    zero_ok = (zero_sel >= pulse_min) && (zero_sel <= pulse_max);
    if (!zero_ok) begin
      unique case (job.ch)
        CH_PITCH: zero_sel = PITCH_FALLBACK;
        CH_ROLL:  zero_sel = ROLL_FALLBACK;
        default:  zero_sel = THROTTLE_FALLBACK;
      endcase
    end
    d      = $signed({1'b0, w}) - $signed({1'b0, zero_sel});
    mag    = d[12] ? 12'(-d) : d[11:0];
    mag_sq = mag * mag;
    v = 14'(d);
    if (v > SMAX) v = SMAX;
    if (v < SMIN) v = SMIN;
    if (job.locked || (v < $signed({4'd0, protect_speed}))) v = '0;
    speed_hit = applied && (job.ch == CH_THROTTLE) && job.manual;
    lock_next = lock_bits;
    if (applied && job.ch == CH_ROLL) begin
      lock_next[2:1] = 2'b00;
      if (d < -ROLL_EXTREME) lock_next[2] = 1'b1;
      else if (d > ROLL_EXTREME) lock_next[1] = 1'b1;
    end else if (applied && job.ch == CH_THROTTLE) begin
      lock_next[0] = (mag < 12'(protect_speed));
    end
    tilt_res = neg ? 17'(-{1'b0, tilt_mag}) : {1'b0, tilt_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min     <= 12'd1000;
      pulse_max     <= 12'd2000;
      pitch_zero    <= 12'd1500;
      roll_zero     <= 12'd1500;
      throttle_zero <= 12'd1100;
      process_var   <= 24'd256;
      measure_var   <= 24'd57600;
      protect_speed <= 10'd50;
      lock_bits     <= '0;
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        width_estimate[i]    <= '0;
        estimate_variance[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PULSE_MIN:     pulse_min     <= cfg_data[11:0];
          REG_PULSE_MAX:     pulse_max     <= cfg_data[11:0];
          REG_PITCH_ZERO:    pitch_zero    <= cfg_data[11:0];
          REG_ROLL_ZERO:     roll_zero     <= cfg_data[11:0];
          REG_THROTTLE_ZERO: throttle_zero <= cfg_data[11:0];
          REG_PROCESS_VAR:   process_var   <= cfg_data;
          REG_MEASURE_VAR:   measure_var   <= cfg_data;
          REG_PROTECT_SPEED: protect_speed <= cfg_data[9:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            job   <= pop_job;
            slot  <= (pop_job.ch == CH_DIAL) ? 2'd3 : pop_job.ch[1:0];
            state <= S_PREP;
          end
        end
        S_PREP: begin
          q2      <= 25'(estimate_variance[slot]) + 25'(process_var);
          den     <= 26'(estimate_variance[slot]) + 26'(process_var) + 26'(measure_var);
          est_cur <= width_estimate[slot];
          if (filt) begin
            state <= S_MUL1;
          end else begin
            w     <= job.raw;
            state <= S_APPLY;
          end
        end
        S_MUL1: begin
          if (den == '0) begin
            w     <= est_cur[19:8];
            state <= S_APPLY;
          end else begin
            meas_lo <= meas < est_cur;
            prod    <= DIV_NW'(45'(meas < est_cur ? est_cur - meas : meas - est_cur)
                       * 45'(q2));
            divisor <= DIV_DW'(den);
            state   <= S_DIVS1;
          end
        end
        S_DIVS1: state <= S_DIVW1;
        S_DIVW1: begin
          if (div_done) begin
            est_new <= meas_lo ? (est_cur - div_q[19:0]) : (est_cur + div_q[19:0]);
            prod    <= DIV_NW'(49'(q2) * 49'(measure_var));
            state   <= S_DIVS2;
          end
        end
        S_DIVS2: state <= S_DIVW2;
        S_DIVW2: begin
          if (div_done) begin
            estimate_variance[slot] <= div_q;
            width_estimate[slot]    <= est_new;
            w     <= est_new[19:8];
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          o_ch      <= job.ch;
          o_w       <= w;
          o_applied <= applied;
          o_tilt    <= '0;
          o_tv      <= 1'b0;
          o_speed   <= speed_hit ? v[9:0] : '0;
          o_sv      <= speed_hit;
          o_lock    <= lock_next;
          lock_bits <= lock_next;
          if (applied && job.ch == CH_PITCH) pitch_zero <= zero_sel;
          if (applied && job.ch == CH_ROLL) roll_zero <= zero_sel;
          if (applied && job.ch == CH_THROTTLE) throttle_zero <= zero_sel;
          if (applied && (job.ch == CH_PITCH || job.ch == CH_ROLL)) begin
            sq    <= (mag_sq > 24'(TILT_SQ_LIMIT)) ? TILT_SQ_LIMIT : mag_sq[17:0];
            neg   <= d[12];
            state <= S_TMUL;
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_TMUL: begin
          prod  <= DIV_NW'(50'(sq) * 50'(PI_Q30)) + DIV_NW'(TILT_HALF);
          state <= S_TRCP;
        end
        S_TRCP: begin
          tilt_mag <= tilt_prod[TILT_RCP_SHIFT+15:TILT_RCP_SHIFT];
          state    <= S_TOUT;
        end
        S_TOUT: begin
          o_tilt    <= tilt_res;
          o_tv      <= 1'b1;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/rc_pwm_channel_decoder.sv
// RC receiver pulse decoder: edge capture, Kalman smoothing, tilt, throttle and lock bits.
// A rising edge records its pulse start time; a falling edge whose width lies in the window is queued
// (four entries) for the back end, which handles one word at a time: throttle, dial, pitch and
// roll go through a filter (two divisions of 24 steps on one shared restoring divider), pitch
// and roll then also get the tilt by reciprocal multiplication, and the raw channels skip both.
// A result word that waits on m_tready holds the back end; the front keeps taking words until
// the queue is full. Words outside the window, rising edges and channels beyond NUM_CHANNELS
// give no result.
module rc_pwm_channel_decoder
  import rcpwm_pkg::*;
#(
  parameter int NUM_CHANNELS = 6,
  parameter int TIME_WIDTH   = 32,
  parameter int SPEED_MAX    = 1000,
  parameter int SPEED_MIN    = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // channel, level, time_us, motor_locked, manual_mode, zero pad
  input  logic [((TIME_WIDTH + 6 + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // out_channel, width_us, applied, tilt_q16, tilt_valid, speed, speed_valid, lock_flags
  output logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  window_t win;
  logic    push;
  job_t    push_job;
  logic    full;
  logic    pop;
  job_t    pop_job;
  logic    empty;

  rcpwm_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ch     (s_tdata[2:0]),
    .in_level  (s_tdata[3]),
    .in_time   (s_tdata[TIME_WIDTH+3:4]),
    .in_locked (s_tdata[TIME_WIDTH+4]),
    .in_manual (s_tdata[TIME_WIDTH+5]),
    .win       (win),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  rcpwm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  rcpwm_back #(
    .SPEED_MAX (SPEED_MAX),
    .SPEED_MIN (SPEED_MIN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win),
    .empty     (empty),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

### tb/rc_pwm_checker.sv
// scoreboard for the rc pwm channel decoder: predicts every output word and compares it
module rc_pwm_checker
  import rcpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int CHANNEL_COUNT = 6;
  localparam longint SPEED_TOP = 1000;
  localparam longint SPEED_BOTTOM = 0;

  typedef struct packed {
    logic [2:0]  lock;
    logic        speed_ok;
    logic [9:0]  speed;
    logic        tilt_ok;
    logic [16:0] tilt;
    logic        applied;
    logic [11:0] width;
    logic [2:0]  ch;
  } decoded_t;

  logic [63:0] min_us, max_us, pitch_zero, roll_zero, thr_zero;
  logic [63:0] proc_var, meas_var, protect;
  logic [31:0] start_time [8];
  logic [63:0] est [4];
  logic [63:0] var_sq [4];
  logic [2:0]  locks;
  decoded_t    expected_q [$];

  function automatic bit in_window(logic [63:0] w);
    return w >= min_us && w <= max_us;
  endfunction

  // signed tilt in radians q16, degrees follow a parabola of the stick offset
  function automatic logic [16:0] tilt_angle(longint d);
    logic [63:0] mag, sq, t;
    mag = (d < 0) ? -d : d;
    sq = mag * mag;
    if (sq > 64'(TILT_SQ_LIMIT)) sq = 64'(TILT_SQ_LIMIT);
    t = (sq * 64'(PI_Q30) + 64'(TILT_HALF)) / 64'(TILT_DEN);
    if (d < 0) t = -t;
    return t[16:0];
  endfunction

  task automatic predict_edge(input logic [39:0] word);
    logic [2:0]  ch;
    logic [31:0] stamp;
    logic [63:0] raw, w, q2, den, meas;
    longint      d, v;
    int          slot;
    decoded_t    r;
    ch = word[2:0];
    stamp = word[35:4];
    if (ch >= CHANNEL_COUNT) return;
    if (word[3]) begin
      start_time[ch] = stamp;
      return;
    end
    raw = 64'(stamp - start_time[ch]);
    if (!in_window(raw)) return;
    if (ch <= CH_THROTTLE || ch == CH_DIAL) begin
      slot = (ch == CH_DIAL) ? 3 : ch;
      q2 = var_sq[slot] + proc_var;
      den = q2 + meas_var;
      meas = raw << 8;
      // zero total variance leaves the filter untouched
      if (den != 0) begin
        if (meas >= est[slot]) est[slot] = est[slot] + (meas - est[slot]) * q2 / den;
        else est[slot] = est[slot] - (est[slot] - meas) * q2 / den;
        est[slot] = est[slot] & 64'hFFFFF;
        var_sq[slot] = (q2 * meas_var / den) & 64'hFFFFFF;
      end
      w = (est[slot] >> 8) & 64'hFFF;
    end else begin
      w = raw;
    end
    r = '0;
    r.ch = ch;
    r.width = w[11:0];
    r.applied = in_window(w);
    if (r.applied && ch == CH_PITCH) begin
      if (!in_window(pitch_zero)) pitch_zero = 64'(PITCH_FALLBACK);
      r.tilt = tilt_angle(longint'(w) - longint'(pitch_zero));
      r.tilt_ok = 1'b1;
    end else if (r.applied && ch == CH_ROLL) begin
      if (!in_window(roll_zero)) roll_zero = 64'(ROLL_FALLBACK);
      d = longint'(w) - longint'(roll_zero);
      r.tilt = tilt_angle(d);
      r.tilt_ok = 1'b1;
      locks[2:1] = 2'b00;
      if (d < -longint'(ROLL_EXTREME)) locks[2] = 1'b1;
      else if (d > longint'(ROLL_EXTREME)) locks[1] = 1'b1;
    end else if (r.applied && ch == CH_THROTTLE) begin
      if (!in_window(thr_zero)) thr_zero = 64'(THROTTLE_FALLBACK);
      d = longint'(w) - longint'(thr_zero);
      v = d;
      if (v > SPEED_TOP) v = SPEED_TOP;
      if (v < SPEED_BOTTOM) v = SPEED_BOTTOM;
      if (word[36] || v < longint'(protect)) v = 0;
      if (word[37]) begin
        r.speed = v[9:0];
        r.speed_ok = 1'b1;
      end
      locks[0] = (((d < 0) ? -d : d) < longint'(protect));
    end
    r.lock = locks;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    decoded_t want, got;
    if (rst) begin
      min_us = 1000; max_us = 2000; pitch_zero = 1500; roll_zero = 1500;
      thr_zero = 1100; proc_var = 256; meas_var = 57600; protect = 50;
      for (int i = 0; i < 8; i++) start_time[i] = '0;
      for (int i = 0; i < 4; i++) begin
        est[i] = '0;
        var_sq[i] = '0;
      end
      locks = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PULSE_MIN:     min_us = 64'(cfg_data[11:0]);
          REG_PULSE_MAX:     max_us = 64'(cfg_data[11:0]);
          REG_PITCH_ZERO:    pitch_zero = 64'(cfg_data[11:0]);
          REG_ROLL_ZERO:     roll_zero = 64'(cfg_data[11:0]);
          REG_THROTTLE_ZERO: thr_zero = 64'(cfg_data[11:0]);
          REG_PROCESS_VAR:   proc_var = 64'(cfg_data);
          REG_MEASURE_VAR:   meas_var = 64'(cfg_data);
          REG_PROTECT_SPEED: protect = 64'(cfg_data[9:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_edge(s_tdata);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word ch %0d width %0d", got.ch, got.width);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch ch %0d/%0d width %0d/%0d applied %0d/%0d tilt %0d/%0d",
                       want.ch, got.ch, want.width, got.width, want.applied, got.applied,
                       $signed(want.tilt), $signed(got.tilt));
              $display("  tilt_valid %0d/%0d speed %0d/%0d speed_valid %0d/%0d lock %0d/%0d",
                       want.tilt_ok, got.tilt_ok, want.speed, got.speed,
                       want.speed_ok, got.speed_ok, want.lock, got.lock);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/tb.sv
// testbench top: edge stimulus, register phases, output back-pressure and verdict
module tb;
  import rcpwm_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_LIMIT = 5000;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [47:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  int          errors, pending;

  logic [31:0] clock_us;
  logic [11:0] win_lo, win_hi;
  bit          calm, locked, manual;
  int          hold, idle;

  rc_pwm_channel_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rc_pwm_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver holds m_tready low for a random stall after each word, with no stall when calm
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      m_tready <= 1'b1;
      hold <= 0;
    end else if (m_tvalid && m_tready) begin
      stall = calm ? 0 : $urandom_range(0, 11);
      hold <= stall;
      m_tready <= (stall == 0);
    end else if (hold > 0) begin
      hold <= hold - 1;
      m_tready <= (hold == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle <= 0;
    end else begin
      idle <= idle + 1;
      if (idle == IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic put_edge(input logic [2:0] ch, input bit level, input logic [31:0] stamp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, manual, locked, stamp, level, ch};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pulse(input logic [2:0] ch, input logic [31:0] width);
    clock_us = clock_us + $urandom_range(1, 40000);
    put_edge(ch, 1'b1, clock_us);
    put_edge(ch, 1'b0, clock_us + width);
  endtask

  // block idle: nothing owed, and any queued word without a result has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input int lo, input int hi, input int pz, input int rz, input int tz,
                            input int pv, input int mv, input int ps);
    write_reg(REG_PULSE_MIN, 24'(lo));
    write_reg(REG_PULSE_MAX, 24'(hi));
    write_reg(REG_PITCH_ZERO, 24'(pz));
    write_reg(REG_ROLL_ZERO, 24'(rz));
    write_reg(REG_THROTTLE_ZERO, 24'(tz));
    write_reg(REG_PROCESS_VAR, 24'(pv));
    write_reg(REG_MEASURE_VAR, 24'(mv));
    write_reg(REG_PROTECT_SPEED, 24'(ps));
    cfg_we <= 1'b0;
    @(posedge clk);
    win_lo = 12'(lo);
    win_hi = 12'(hi);
  endtask

  function automatic int pick_var();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 24'hFFFFFF;
      2: return $urandom_range(0, 2000);
      default: return $urandom_range(0, 24'hFFFFFF);
    endcase
  endfunction

  function automatic int pick_zero();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1000, 2000);
  endfunction

  task automatic random_phase(input int n_pulses);
    int lo, hi, ch, w;
    lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(700, 1200);
    hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1800, 3500);
    set_config(lo, hi, pick_zero(), pick_zero(), pick_zero(), pick_var(), pick_var(),
               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120));
    for (int i = 0; i < n_pulses; i++) begin
      locked = $urandom_range(0, 3) == 0;
      manual = $urandom_range(0, 3) != 0;
      ch = $urandom_range(0, 5);
      case ($urandom_range(0, 9))
        8: put_edge(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom());
        9: pulse(3'(ch), $urandom());
        default: begin
          w = (win_lo <= win_hi) ? $urandom_range(win_lo, win_hi) : $urandom_range(0, 4095);
          if ($urandom_range(0, 7) == 0) w = w + $urandom_range(0, 4) - 2;
          pulse(3'(ch), 32'(w));
        end
      endcase
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PULSE_MIN;
    cfg_data = '0;
    calm = 1'b0;
    locked = 1'b0;
    manual = 1'b1;
    clock_us = 32'h0000_1000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no measurement noise: the filter follows the raw width exactly
    set_config(1000, 2000, 1500, 1500, 1100, 256, 0, 50);
    pulse(CH_PITCH, 1000);
    pulse(CH_PITCH, 2000);
    pulse(CH_PITCH, 1500);
    pulse(CH_ROLL, 1300);
    pulse(CH_ROLL, 1700);
    pulse(CH_ROLL, 1500);
    pulse(CH_THROTTLE, 1100);
    pulse(CH_THROTTLE, 1900);
    locked = 1'b1;
    pulse(CH_THROTTLE, 1900);
    locked = 1'b0;
    manual = 1'b0;
    pulse(CH_THROTTLE, 1600);
    manual = 1'b1;
    pulse(3'd3, 999);
    pulse(3'd4, 2001);
    pulse(3'd4, 1234);
    put_edge(3'd6, 1'b1, 32'h0);
    put_edge(3'd7, 1'b0, 32'hFFFF_FFFF);
    // pulse straddling the timestamp wrap
    clock_us = 32'hFFFF_F000;
    pulse(CH_DIAL, 4095);
    settle();

    // centre registers outside the window fall back
    set_config(1000, 2000, 4000, 0, 3000, 0, 0, 1023);
    pulse(CH_PITCH, 1800);
    pulse(CH_ROLL, 1200);
    pulse(CH_THROTTLE, 2000);
    settle();
    set_config(0, 4095, 0, 4095, 0, 24'hFFFFFF, 24'hFFFFFF, 0);
    pulse(CH_PITCH, 4095);
    pulse(CH_ROLL, 0);
    pulse(CH_THROTTLE, 4095);
    settle();
    // inverted window drops everything
    set_config(3000, 100, 1500, 1500, 1100, 256, 57600, 50);
    pulse(CH_PITCH, 1500);
    pulse(3'd3, 2000);
    settle();

    for (int p = 0; p < 10; p++) begin
      calm = (p % 4 == 3);
      random_phase(50);
    end
    calm = 1'b0;
    set_config(1000, 2000, 1500, 1500, 1100, 256, 57600, 50);
    random_phase(20);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
